[hw/rtl/rfrld_pkg.sv]
`default_nettype none

package rfrld_pkg;

  // Widths of positions, configuration registers and payload fields
  localparam int POS_W      = 24;
  localparam int DATA_W     = 8;
  localparam int CNT_W      = 9;
  localparam int SHIFT_W    = 4;
  localparam int OBJ_W      = 4;
  localparam int CFG_IDX_W  = 2;

  // Format constants
  localparam int SHIFT_MAX    = 8;
  localparam int OBJ_PER_FLAG = 8;
  localparam int FULL_RUN     = 256;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd2;

  // Fault codes
  localparam logic [1:0] FAULT_NONE  = 2'd0;
  localparam logic [1:0] FAULT_SHIFT = 2'd1;
  localparam logic [1:0] FAULT_COUNT = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_FIRST,
    PH_OBJ
  } phase_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              begin_req;
    logic              final_byte;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] run_value;
    logic [POS_W-1:0]  out_index;
    logic [CNT_W-1:0]  run_count;
    logic              done_res;
    logic [1:0]        fault;
  } out_item_t;

  typedef struct packed {
    logic [POS_W-1:0] total_size;
    logic [POS_W-1:0] window_offset;
    logic [POS_W-1:0] window_length;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [SHIFT_W-1:0] trailer_shift;
    logic [DATA_W-1:0]  flag_bits;
    logic [OBJ_W-1:0]   objects_left;
    logic [DATA_W-1:0]  pending_value;
    logic               awaiting_count;
    logic [POS_W-1:0]   position;
  } dec_state_t;

endpackage

`default_nettype wire

[hw/rtl/reverse_flagged_run_length_decoder.sv]
`default_nettype none

// Channel   Direction  Payload     Handshake
// in        input      in_data     in_valid / in_stall
// out       output     out_data    out_valid / out_stall
// cfg       input      cfg_data    cfg_we / cfg_index
//
// One compressed byte per cycle while the output is not stalled. A byte is held in the input register,
// is decoded there, and its run record (if any) lands in the output register
// once the output register is free to take it.
// Reset clears the decoder state and the configuration registers.
// A stalled output register stalls the input register, which stalls the input.

module reverse_flagged_run_length_decoder (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire rfrld_pkg::in_item_t          in_data,
  output logic                              out_valid,
  input  wire                               out_stall,
  output rfrld_pkg::out_item_t              out_data,
  input  wire                               cfg_we,
  input  wire [rfrld_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire [rfrld_pkg::POS_W-1:0]        cfg_data
);

  rfrld_pkg::cfg_t       cfg;
  rfrld_pkg::dec_state_t state;
  rfrld_pkg::dec_state_t state_next;
  rfrld_pkg::in_item_t   in_q;
  logic                  in_full;
  rfrld_pkg::out_item_t  res;
  logic                  res_valid;
  logic                  out_free;
  logic                  advance;
  logic                  in_take;

  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rfrld_pkg::CFG_TOTAL_SIZE:    cfg.total_size    <= cfg_data;
        rfrld_pkg::CFG_WINDOW_OFFSET: cfg.window_offset <= cfg_data;
        rfrld_pkg::CFG_WINDOW_LENGTH: cfg.window_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q <= in_data;
    end
  end

  rfrld_step u_step (
    .cfg       (cfg),
    .cur       (state),
    .item      (in_q),
    .nxt       (state_next),
    .res_valid (res_valid),
    .res       (res)
  );

  // Advance decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{phase:          rfrld_pkg::PH_IDLE,
                 trailer_shift:  '0,
                 flag_bits:      '0,
                 objects_left:   '0,
                 pending_value:  '0,
                 awaiting_count: 1'b0,
                 position:       '0};
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/rfrld_step.sv]
`default_nettype none

module rfrld_step (
  input  wire rfrld_pkg::cfg_t       cfg,
  input  wire rfrld_pkg::dec_state_t cur,
  input  wire rfrld_pkg::in_item_t   item,
  output rfrld_pkg::dec_state_t      nxt,
  output logic                       res_valid,
  output rfrld_pkg::out_item_t       res
);

  logic [rfrld_pkg::POS_W-1:0] t_size;
  logic [rfrld_pkg::POS_W-1:0] w_off;
  logic [rfrld_pkg::POS_W-1:0] w_len;
  logic [rfrld_pkg::POS_W-1:0] t_minus_o;
  logic [rfrld_pkg::POS_W-1:0] w_end;
  logic                        win_empty;
  logic                        begin_empty;
  logic                        cur_empty;
  logic [rfrld_pkg::POS_W-1:0] hi;
  logic [rfrld_pkg::CNT_W-1:0] obj_cnt;
  logic [rfrld_pkg::POS_W-1:0] cnt_ext;
  logic [rfrld_pkg::POS_W-1:0] lo_run;
  logic [rfrld_pkg::POS_W-1:0] lo;
  logic [rfrld_pkg::POS_W-1:0] written;
  logic                        run_done;
  logic [rfrld_pkg::DATA_W-1:0] run_val;
  logic                        is_run;

  assign t_size = cfg.total_size;
  assign w_off  = cfg.window_offset;
  assign w_len  = cfg.window_length;

  // Window end, with the length clamped to the image size
  assign t_minus_o = t_size - w_off;
  always_comb begin
    if (w_off >= t_size) begin
      w_end = w_off;
    end else if (w_len > t_minus_o) begin
      w_end = t_size;
    end else begin
      w_end = w_off + w_len;
    end
  end

  assign win_empty   = (w_end <= w_off);
  assign begin_empty = (t_size <= w_off) || win_empty;
  assign cur_empty   = (cur.position <= w_off) || win_empty;

  // Run extent: a count byte gives a pair run, otherwise a single literal
  assign obj_cnt = cur.awaiting_count
                   ? ((item.data_byte == '0) ? rfrld_pkg::CNT_W'(rfrld_pkg::FULL_RUN)
                                             : {1'b0, item.data_byte})
                   : rfrld_pkg::CNT_W'(1);
  assign run_val = cur.awaiting_count ? cur.pending_value : item.data_byte;
  assign cnt_ext = rfrld_pkg::POS_W'(obj_cnt);
  assign hi      = (cur.position < w_end) ? cur.position : w_end;
  assign lo_run  = (cur.position > cnt_ext) ? (cur.position - cnt_ext) : '0;
  assign lo      = (lo_run > w_off) ? lo_run : w_off;
  assign written = (hi > lo) ? (hi - lo) : '0;
  assign run_done = item.final_byte || (lo_run <= w_off) || win_empty;
  assign is_run  = cur.awaiting_count || (cur.objects_left != '0 && !cur.flag_bits[0]);

  // Decode one byte
  always_comb begin
    nxt       = cur;
    res_valid = 1'b0;
    res       = '0;
    if (item.begin_req) begin
      // Restart the image from the shift byte
      nxt.flag_bits      = '0;
      nxt.objects_left   = '0;
      nxt.pending_value  = '0;
      nxt.awaiting_count = 1'b0;
      nxt.phase          = rfrld_pkg::PH_IDLE;
      nxt.trailer_shift  = '0;
      nxt.position       = t_size;
      if (item.data_byte > rfrld_pkg::DATA_W'(rfrld_pkg::SHIFT_MAX)) begin
        res_valid = 1'b1;
        res.done_res = 1'b1;
        res.fault    = rfrld_pkg::FAULT_SHIFT;
      end else begin
        nxt.trailer_shift = item.data_byte[rfrld_pkg::SHIFT_W-1:0];
        if (item.final_byte || begin_empty) begin
          res_valid    = 1'b1;
          res.done_res = 1'b1;
        end else begin
          nxt.phase = rfrld_pkg::PH_FIRST;
        end
      end
    end else if (cur.phase == rfrld_pkg::PH_IDLE) begin
      // Drop bytes while idle
      nxt = cur;
    end else if (cur_empty) begin
      nxt.phase          = rfrld_pkg::PH_IDLE;
      nxt.awaiting_count = 1'b0;
      res_valid          = 1'b1;
      res.done_res       = 1'b1;
    end else if (cur.phase == rfrld_pkg::PH_FIRST) begin
      // First flag byte, pre-shifted by the trailer count
      nxt.flag_bits    = (cur.trailer_shift >= rfrld_pkg::SHIFT_W'(rfrld_pkg::SHIFT_MAX))
                         ? '0 : (item.data_byte >> cur.trailer_shift);
      nxt.objects_left = rfrld_pkg::OBJ_W'(rfrld_pkg::OBJ_PER_FLAG) - cur.trailer_shift;
      nxt.phase        = rfrld_pkg::PH_OBJ;
      if (item.final_byte) begin
        nxt.phase    = rfrld_pkg::PH_IDLE;
        res_valid    = 1'b1;
        res.done_res = 1'b1;
      end
    end else if (is_run) begin
      // Emit the run clipped to the window
      nxt.position       = lo;
      nxt.flag_bits      = cur.flag_bits >> 1;
      nxt.objects_left   = cur.objects_left - rfrld_pkg::OBJ_W'(1);
      nxt.awaiting_count = 1'b0;
      if (run_done) begin
        nxt.phase = rfrld_pkg::PH_IDLE;
      end
      if (written == '0) begin
        res_valid    = run_done;
        res.done_res = 1'b1;
      end else begin
        res_valid     = 1'b1;
        res.run_value = run_val;
        res.out_index = lo - w_off;
        res.run_count = written[rfrld_pkg::CNT_W-1:0];
        res.done_res  = run_done;
      end
    end else if (cur.objects_left == '0) begin
      // Next flag byte
      nxt.flag_bits    = item.data_byte;
      nxt.objects_left = rfrld_pkg::OBJ_W'(rfrld_pkg::OBJ_PER_FLAG);
      if (item.final_byte) begin
        nxt.phase    = rfrld_pkg::PH_IDLE;
        res_valid    = 1'b1;
        res.done_res = 1'b1;
      end
    end else begin
      // Value byte of a pair; hold it until the count arrives
      nxt.pending_value  = item.data_byte;
      nxt.awaiting_count = 1'b1;
      if (item.final_byte) begin
        nxt.phase          = rfrld_pkg::PH_IDLE;
        nxt.awaiting_count = 1'b0;
        res_valid          = 1'b1;
        res.done_res       = 1'b1;
        res.fault          = rfrld_pkg::FAULT_COUNT;
      end
    end
  end

endmodule

`default_nettype wire
